FILE: sv/linear_interp_resampler_macros.svh
// ----------------------------------------------------------------------------
// Linear interpolation resampler - assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

// Same-cycle implication
`define LIR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

// Next-cycle implication
`define LIR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`endif

FILE: sv/lir_pkg.sv
// ----------------------------------------------------------------------------
// lir_pkg
// Shared constants and controller/datapath interface types of the resampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lir_pkg;

  // Fixed point format of phase and step
  localparam int FRAC_BITS = 16;
  localparam int PHASE_W   = FRAC_BITS + 2;
  // Running phase holds phase + two steps
  localparam int T_W       = FRAC_BITS + 4;
  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = SAMPLE_W + FRAC_BITS;

  localparam logic [PHASE_W-1:0] ONE_Q      = PHASE_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_LOW   = PHASE_W'(1) << (FRAC_BITS - 1);
  localparam logic [PHASE_W-1:0] STEP_HIGH  = PHASE_W'(3) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(3) << (FRAC_BITS - 1);

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture input sample, optional stream restart
    logic mul;     // register |cur - prev| * phase
    logic emit;    // load interpolated result, advance phase
    logic pass;    // load input sample unchanged
    logic finish;  // wrap phase, keep sample as previous
  } lir_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pass_mode;  // step is exactly one
    logic t_lt_one;   // running phase below one
    logic last;       // result being formed is the final one
    logic out_free;   // output register can take a result
  } lir_stat_t;

endpackage

`default_nettype wire

FILE: sv/lir_ctrl.sv
// ----------------------------------------------------------------------------
// lir_ctrl
// Sequencer: one input at a time, a multiply state and an emit state per result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_ctrl
  import lir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire lir_stat_t stat,
  output lir_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_EMIT = 5'b00100,
    S_FIN  = 5'b01000,
    S_PASS = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = stat.pass_mode ? S_PASS : S_MUL;
        end
      end
      S_MUL: begin
        if (stat.t_lt_one) begin
          cmd.mul   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.last ? S_FIN : S_MUL;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_PASS: begin
        if (stat.out_free) begin
          cmd.pass  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/lir_dp.sv
// ----------------------------------------------------------------------------
// lir_dp
// Datapath: step register, sample/phase state, multiplier and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lir_dp
  import lir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [PHASE_W-1:0]  cfg_wr_data,
  input  wire logic [SAMPLE_W-1:0] in_tdata,   // [15:0] sample
  input  wire logic                in_tuser,   // [0] new_stream
  output logic      [SAMPLE_W-1:0] out_tdata,  // [15:0] out_sample
  output logic                     out_tlast,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  input  wire lir_cmd_t            cmd,
  output lir_stat_t                stat
);

  logic        [PHASE_W-1:0]  step_r;
  logic        [PHASE_W-1:0]  phase_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  logic signed [SAMPLE_W-1:0] cur_r;
  logic        [T_W-1:0]      t_r;
  logic                       cnt_r;
  logic        [PROD_W-1:0]   prod_r;
  logic                       neg_r;
  logic        [SAMPLE_W-1:0] out_data_r;
  logic                       out_last_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W:0]   diff_c;
  logic        [SAMPLE_W-1:0] mag_c;
  logic        [SAMPLE_W-1:0] q_c;
  logic signed [SAMPLE_W:0]   y_c;
  logic        [T_W-1:0]      t_sum_c;
  logic                       last_c;
  logic                       out_free_c;

  // Interpolation terms
  assign diff_c  = {cur_r[SAMPLE_W-1], cur_r} - {prev_r[SAMPLE_W-1], prev_r};
  assign mag_c   = diff_c[SAMPLE_W] ? SAMPLE_W'(-diff_c) : diff_c[SAMPLE_W-1:0];
  assign q_c     = prod_r[PROD_W-1:FRAC_BITS];
  assign y_c     = {prev_r[SAMPLE_W-1], prev_r}
                 + (neg_r ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c}));

  // Loop control
  assign t_sum_c    = t_r + T_W'(step_r);
  assign last_c     = cnt_r || (t_sum_c[T_W-1:FRAC_BITS] != '0);
  assign out_free_c = !out_valid_r || out_tready;

  assign stat.pass_mode = (step_r == ONE_Q);
  assign stat.t_lt_one  = (t_r[T_W-1:FRAC_BITS] == '0);
  assign stat.last      = last_c;
  assign stat.out_free  = out_free_c;

  // Step register, out-of-range writes take the reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_wr_data < STEP_LOW || cfg_wr_data > STEP_HIGH) begin
        step_r <= STEP_RESET;
      end else begin
        step_r <= cfg_wr_data;
      end
    end
  end

  // Stream state: previous sample and phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      phase_r <= '0;
    end else if (cmd.load && in_tuser) begin
      prev_r  <= '0;
      phase_r <= '0;
    end else if (cmd.finish) begin
      prev_r  <= cur_r;
      phase_r <= PHASE_W'(t_r - T_W'(ONE_Q));
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= in_tdata;
      t_r   <= in_tuser ? '0 : T_W'(phase_r);
      cnt_r <= 1'b0;
    end else if (cmd.emit) begin
      t_r   <= t_sum_c;
      cnt_r <= 1'b1;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag_c) * PROD_W'(t_r[FRAC_BITS-1:0]);
      neg_r  <= diff_c[SAMPLE_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.pass) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= y_c[SAMPLE_W-1:0];
      out_last_r <= last_c;
    end else if (cmd.pass) begin
      out_data_r <= cur_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: sv/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter for signed 16-bit mono audio.
// ----------------------------------------------------------------------------
// One input sample is taken at a time. Each result passes through the shared
// 16 x 16 multiplier and then a state that forms and registers it, which
// waits while the output register cannot take it; a resampled input then
// ends in a finish state. In passthrough (step exactly 1.0) the input sample
// is loaded unchanged into the output register. The step is a Q2.16 value
// written on cfg_wr_*; values outside 0.5..3.0 load the default 1.5. in_tuser
// restarts the stream. out_tlast marks the final result caused by an input;
// an input may cause no result at all. A finished result waits in the output
// register while the next input is accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler
  import lir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [PHASE_W-1:0]  cfg_wr_data,  // phase_step, unsigned Q2.16
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [SAMPLE_W-1:0] in_tdata,     // [15:0] sample
  input  wire logic                in_tuser,     // [0] new_stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic      [SAMPLE_W-1:0] out_tdata,    // [15:0] out_sample
  output logic                     out_tlast
);

  lir_cmd_t  cmd;
  lir_stat_t stat;

  lir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lir_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // Checks
  `LIR_ASSERT_IMP(a_no_overwrite, cmd.emit || cmd.pass, !out_tvalid || out_tready)
  `LIR_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `LIR_ASSERT_NXT(a_last_ends_loop, cmd.emit && stat.last, cmd.finish && !cmd.emit)
  `LIR_ASSERT_NXT(a_finish_to_idle, cmd.finish, in_tready)

endmodule

`default_nettype wire
